// ----- rtl/core/fmc_pkg.sv -----
// Shared types, constants and brand tables for the file magic classifier.
// Used by every module in rtl/core; depends on nothing else.
package fmc_pkg;

  localparam int HEAD_BYTES_DEFAULT = 4096;
  localparam int PREFIX_DEPTH = 18;
  localparam int AVAIL_W = 5;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    CLASS_UNKNOWN = 3'd0,
    CLASS_IMAGE   = 3'd1,
    CLASS_MEDIA   = 3'd2,
    CLASS_PDF     = 3'd3,
    CLASS_ZIP     = 3'd4
  } format_class_t;

  typedef struct packed {
    byte_t [PREFIX_DEPTH-1:0] prefix;
    logic [AVAIL_W-1:0]       avail;
    logic                     still_seen;
    logic                     seq_seen;
    logic                     pdf_found;
    logic                     truncated;
  } head_view_t;

  typedef struct packed {
    format_class_t fmt;
    logic          truncated;
  } result_t;

  localparam byte_t ASF_GUID [16] = '{
    8'h30, 8'h26, 8'hB2, 8'h75, 8'h8E, 8'h66, 8'hCF, 8'h11,
    8'hA6, 8'hD9, 8'h00, 8'hAA, 8'h00, 8'h62, 8'hCE, 8'h6C
  };

  function automatic logic is_sequence_brand(input logic [31:0] b);
    return (b == "msf1") || (b == "hevc") || (b == "hevx") || (b == "hevm") ||
           (b == "hevs") || (b == "avis") || (b == "avcs");
  endfunction

  function automatic logic is_still_brand(input logic [31:0] b);
    return (b == "mif1") || (b == "mif2") || (b == "heic") || (b == "heix") ||
           (b == "heim") || (b == "heis") || (b == "avif") || (b == "avci") ||
           (b == "crx ");
  endfunction

  function automatic byte_t pdf_mark(input logic [2:0] pos);
    byte_t m;
    unique case (pos)
      3'd0:    m = "%";
      3'd1:    m = "P";
      3'd2:    m = "D";
      3'd3:    m = "F";
      3'd4:    m = "-";
      default: m = "%";
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/fmc_tracker.sv -----
// Per-byte state of the file head: byte count, prefix bytes, ftyp brand walk
// and the %PDF- search. Depends on fmc_pkg.
module fmc_tracker #(
  parameter int HEAD_BYTES = fmc_pkg::HEAD_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic               last,
  input  fmc_pkg::byte_t     data_byte,
  output fmc_pkg::head_view_t view
);

  localparam int CNT_W = $clog2(HEAD_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_HEAD = CNT_W'(HEAD_BYTES);
  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(HEAD_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_PREFIX = CNT_W'(fmc_pkg::PREFIX_DEPTH);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  fmc_pkg::byte_t   prefix_r   [fmc_pkg::PREFIX_DEPTH];
  fmc_pkg::byte_t   prefix_nxt [fmc_pkg::PREFIX_DEPTH];
  logic [31:0]      box_r, box_nxt;
  logic [31:0]      brand_r, brand_nxt;
  logic             still_r, still_nxt;
  logic             seq_r, seq_nxt;
  logic [2:0]       prog_r, prog_nxt;
  logic             found_r, found_nxt;
  logic [31:0]      bound;
  logic             brand_slot;

  assign bound = (box_r < 32'd12) ? 32'd12 : box_r;
  assign brand_slot = ((cnt_r == CNT_W'(11)) ||
                       ((cnt_r >= CNT_W'(19)) && (cnt_r[1:0] == 2'b11))) &&
                      ((32'(cnt_r) + 32'd1) <= bound);

  always_comb begin
    cnt_nxt   = cnt_r;
    box_nxt   = box_r;
    brand_nxt = brand_r;
    still_nxt = still_r;
    seq_nxt   = seq_r;
    prog_nxt  = prog_r;
    found_nxt = found_r;
    for (int k = 0; k < fmc_pkg::PREFIX_DEPTH; k++) begin
      prefix_nxt[k] = prefix_r[k];
    end
    if (take) begin
      if (cnt_r < CNT_HEAD) begin
        cnt_nxt = cnt_r + CNT_W'(1);
        for (int k = 0; k < fmc_pkg::PREFIX_DEPTH; k++) begin
          if (cnt_r == CNT_W'(k)) begin
            prefix_nxt[k] = data_byte;
          end
        end
        if (cnt_r < CNT_W'(4)) begin
          box_nxt = {box_r[23:0], data_byte};
        end
        brand_nxt = {brand_r[23:0], data_byte};
        if (brand_slot) begin
          if (fmc_pkg::is_sequence_brand(brand_nxt)) begin
            seq_nxt = 1'b1;
          end
          if (fmc_pkg::is_still_brand(brand_nxt)) begin
            still_nxt = 1'b1;
          end
        end
        if (!found_r) begin
          if (data_byte == fmc_pkg::pdf_mark(prog_r)) begin
            if (prog_r == 3'd4) begin
              found_nxt = 1'b1;
              prog_nxt  = 3'd0;
            end else begin
              prog_nxt = prog_r + 3'd1;
            end
          end else begin
            prog_nxt = (data_byte == "%") ? 3'd1 : 3'd0;
          end
        end
      end else begin
        cnt_nxt = CNT_OVER;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < fmc_pkg::PREFIX_DEPTH; k++) begin
      view.prefix[k] = prefix_nxt[k];
    end
    view.avail      = (cnt_nxt >= CNT_PREFIX) ? fmc_pkg::AVAIL_W'(fmc_pkg::PREFIX_DEPTH)
                                              : cnt_nxt[fmc_pkg::AVAIL_W-1:0];
    view.still_seen = still_nxt;
    view.seq_seen   = seq_nxt;
    view.pdf_found  = found_nxt;
    view.truncated  = (cnt_nxt == CNT_OVER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      cnt_r   <= '0;
      box_r   <= '0;
      brand_r <= '0;
      still_r <= 1'b0;
      seq_r   <= 1'b0;
      prog_r  <= '0;
      found_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      box_r   <= box_nxt;
      brand_r <= brand_nxt;
      still_r <= still_nxt;
      seq_r   <= seq_nxt;
      prog_r  <= prog_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < fmc_pkg::PREFIX_DEPTH; k++) begin
      prefix_r[k] <= prefix_nxt[k];
    end
  end

  a_head_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last) |=> (cnt_r == '0) && !found_r && (prog_r == 3'd0))
    else $error("head state not cleared after the last byte");
  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    prog_r <= 3'd4)
    else $error("pdf match progress out of range");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_OVER)
    else $error("byte count past saturation");

endmodule

// ----- rtl/core/fmc_classify.sv -----
// Priority signature checks over the prefix bytes and the walk flags.
// Pure combinational; depends on fmc_pkg.
module fmc_classify (
  input  fmc_pkg::head_view_t view,
  output fmc_pkg::result_t    res
);

  fmc_pkg::byte_t [fmc_pkg::PREFIX_DEPTH-1:0] p;
  logic [fmc_pkg::AVAIL_W-1:0] a;
  logic [31:0] w0, w4, w8, dib;
  logic        is_image, is_riff, is_ftyp, is_media, is_id3, is_zip, asf;

  assign p   = view.prefix;
  assign a   = view.avail;
  assign w0  = {p[0], p[1], p[2], p[3]};
  assign w4  = {p[4], p[5], p[6], p[7]};
  assign w8  = {p[8], p[9], p[10], p[11]};
  assign dib = {p[17], p[16], p[15], p[14]};

  always_comb begin
    asf = (a >= 5'd16);
    for (int k = 0; k < 16; k++) begin
      if (p[k] != fmc_pkg::ASF_GUID[k]) begin
        asf = 1'b0;
      end
    end
  end

  assign is_image =
    ((a >= 5'd8) && (w0 == 32'h89504E47) && (w4 == 32'h0D0A1A0A)) ||
    ((a >= 5'd3) && (p[0] == 8'hFF) && (p[1] == 8'hD8) && (p[2] == 8'hFF)) ||
    ((a >= 5'd6) && (w0 == "GIF8") && ((p[4] == "7") || (p[4] == "9")) &&
     (p[5] == "a")) ||
    ((a >= 5'd4) && ((w0 == 32'h49492A00) || (w0 == 32'h4D4D002A))) ||
    ((a >= 5'd18) && (p[0] == "B") && (p[1] == "M") &&
     ((dib == 32'd12) || (dib == 32'd40) || (dib == 32'd52) || (dib == 32'd56) ||
      (dib == 32'd64) || (dib == 32'd108) || (dib == 32'd124)));

  assign is_riff = (a >= 5'd4) && (w0 == "RIFF");
  assign is_ftyp = (a >= 5'd8) && (w4 == "ftyp");

  assign is_media = asf ||
    ((a >= 5'd4) && ((w0 == 32'h1A45DFA3) || (w0 == "OggS") || (w0 == "fLaC") ||
                     (w0 == 32'h464C5601) || (w0 == 32'h000001BA) ||
                     (w0 == 32'h000001B3)));

  assign is_id3 = (a >= 5'd4) && (p[0] == "I") && (p[1] == "D") && (p[2] == "3") &&
                  (p[3] >= 8'd2) && (p[3] <= 8'd4);

  assign is_zip = (a >= 5'd4) && (p[0] == "P") && (p[1] == "K") &&
                  (({p[2], p[3]} == 16'h0304) || ({p[2], p[3]} == 16'h0506) ||
                   ({p[2], p[3]} == 16'h0708));

  always_comb begin
    res.truncated = view.truncated;
    priority if (is_image) begin
      res.fmt = fmc_pkg::CLASS_IMAGE;
    end else if (is_riff) begin
      if ((a >= 5'd12) && (w8 == "WEBP")) begin
        res.fmt = fmc_pkg::CLASS_IMAGE;
      end else if ((a >= 5'd12) && ((w8 == "AVI ") || (w8 == "WAVE"))) begin
        res.fmt = fmc_pkg::CLASS_MEDIA;
      end else begin
        res.fmt = fmc_pkg::CLASS_UNKNOWN;
      end
    end else if (is_ftyp) begin
      if (view.seq_seen) begin
        res.fmt = fmc_pkg::CLASS_UNKNOWN;
      end else if (view.still_seen) begin
        res.fmt = fmc_pkg::CLASS_IMAGE;
      end else begin
        res.fmt = fmc_pkg::CLASS_MEDIA;
      end
    end else if (is_media || is_id3) begin
      res.fmt = fmc_pkg::CLASS_MEDIA;
    end else if (is_zip) begin
      res.fmt = fmc_pkg::CLASS_ZIP;
    end else if (view.pdf_found) begin
      res.fmt = fmc_pkg::CLASS_PDF;
    end else begin
      res.fmt = fmc_pkg::CLASS_UNKNOWN;
    end
  end

endmodule

// ----- rtl/core/fmc_out_buf.sv -----
// Two-entry result register that parts the byte side from the result side.
// Depends on fmc_pkg.
module fmc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fmc_pkg::result_t din,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output fmc_pkg::result_t dout
);

  localparam logic [1:0] CNT_FULL = 2'd2;

  logic [1:0]       cnt_r, cnt_nxt;
  fmc_pkg::result_t slot0_r, slot0_nxt;
  fmc_pkg::result_t slot1_r, slot1_nxt;
  logic             pop;

  assign full      = (cnt_r == CNT_FULL);
  assign out_valid = (cnt_r != 2'd0);
  assign dout      = slot0_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
    if (push) begin
      if (cnt_nxt == 2'd0) begin
        slot0_nxt = din;
      end else begin
        slot1_nxt = din;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CNT_FULL))
    else $error("result pushed into a full buffer");
  a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !out_stall) |=> (cnt_r == 2'd1))
    else $error("full buffer did not drain by one");
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(dout)))
    else $error("stalled result changed");

endmodule

// ----- rtl/core/file_magic_classifier.sv -----
// Top level of the file magic classifier: byte tracker, signature checks and
// result buffer. Depends on fmc_pkg, fmc_tracker, fmc_classify, fmc_out_buf.
//
// Usage: the head of a file is sent one byte per request on the in_ channel,
// in file order, with in_last_byte set on the final byte. Each head gives one
// request on the out_ channel: out_format_class (0 unknown, 1 image, 2 media,
// 3 pdf, 4 zip) and out_truncated, set when bytes past HEAD_BYTES were dropped.
// A byte is taken at a clock edge with in_valid high and in_stall low; a
// result goes out at an edge with out_valid high and out_stall low.
// Throughput is one byte per cycle while in_stall is low. The result of a head is
// registered into the result buffer on the edge that takes its last byte and is
// offered once the results ahead of it have gone out. Byte state updates and the
// signature checks sit between the tracker registers and a two-entry result buffer.
// While the receiver stalls, bytes keep flowing; in_stall rises only when two
// results are waiting. Synchronous reset clears the tracker and empties the
// buffer; the next byte then starts a new head.
module file_magic_classifier #(
  parameter int HEAD_BYTES = fmc_pkg::HEAD_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_format_class,
  output logic       out_truncated
);

  logic                accept;
  logic                full;
  fmc_pkg::head_view_t view;
  fmc_pkg::result_t    res;
  fmc_pkg::result_t    dout;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  fmc_tracker #(
    .HEAD_BYTES(HEAD_BYTES)
  ) u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (accept),
    .last     (in_last_byte),
    .data_byte(in_data_byte),
    .view     (view)
  );

  fmc_classify u_classify (
    .view(view),
    .res (res)
  );

  fmc_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept && in_last_byte),
    .din      (res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dout     (dout)
  );

  assign out_format_class = dout.fmt;
  assign out_truncated    = dout.truncated;

endmodule

// ----- tb/file_magic_classifier_tb.sv -----
// Self-checking testbench for file_magic_classifier: streams file heads through
// the byte channel and compares every class result with an in-bench predictor.
// Depends on fmc_pkg and the file_magic_classifier RTL only.
module file_magic_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAD_LIMIT = fmc_pkg::HEAD_BYTES_DEFAULT;
  localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
  localparam logic [127:0] ASF_MAGIC = 128'h3026B2758E66CF11A6D900AA0062CE6C;
  localparam logic [39:0] PDF_MARKER = "%PDF-";
  localparam logic [31:0] SEQUENCE_BRANDS [7] = '{
    "msf1", "hevc", "hevx", "hevm", "hevs", "avis", "avcs"
  };
  localparam logic [31:0] STILL_BRANDS [9] = '{
    "mif1", "mif2", "heic", "heix", "heim", "heis", "avif", "avci", "crx "
  };
  localparam logic [31:0] MEDIA_MAGIC [6] = '{
    32'h1A45DFA3, "OggS", "fLaC", 32'h464C5601, 32'h000001BA, 32'h000001B3
  };
  localparam logic [31:0] ZIP_MARKS [3] = '{32'h504B0304, 32'h504B0506, 32'h504B0708};
  localparam logic [31:0] DIB_SIZES [7] = '{12, 40, 52, 56, 64, 108, 124};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_format_class;
  logic       out_truncated;

  file_magic_classifier #(.HEAD_BYTES(HEAD_LIMIT)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_format_class(out_format_class),
    .out_truncated(out_truncated)
  );

  always #5 clk = ~clk;

  logic [12:0]    head_count;
  fmc_pkg::byte_t head_prefix [fmc_pkg::PREFIX_DEPTH];
  logic [31:0]    box_size;
  logic [31:0]    brand_window;
  logic           still_brand;
  logic           sequence_brand;
  logic [2:0]     pdf_progress;
  logic           pdf_found;

  fmc_pkg::result_t expected_classes [$];
  fmc_pkg::byte_t   head_bytes [$];
  int      mismatch_count = 0;
  bit      tx_idle = 1'b1;
  bit      rx_idle = 1'b1;
  int      rx_hold_cycles = 0;

  function automatic void clear_head();
    head_count = '0;
    foreach (head_prefix[k]) head_prefix[k] = '0;
    box_size = '0;
    brand_window = '0;
    still_brand = 1'b0;
    sequence_brand = 1'b0;
    pdf_progress = '0;
    pdf_found = 1'b0;
  endfunction

  function automatic int head_len();
    return (head_count > HEAD_LIMIT) ? HEAD_LIMIT : int'(head_count);
  endfunction

  function automatic logic prefix_has(int off, int len, logic [127:0] sig);
    if (head_len() < off + len || off + len > fmc_pkg::PREFIX_DEPTH) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (head_prefix[off + k] != sig[8 * (len - 1 - k) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic brand_listed(logic [31:0] b, logic still);
    if (still) begin
      for (int k = 0; k < 9; k++) if (STILL_BRANDS[k] == b) return 1'b1;
    end else begin
      for (int k = 0; k < 7; k++) if (SEQUENCE_BRANDS[k] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic fmc_pkg::format_class_t classify_head();
    logic [31:0] dib;
    logic        bitmap;
    logic        media;
    logic        zip;
    dib = {head_prefix[17], head_prefix[16], head_prefix[15], head_prefix[14]};
    bitmap = 1'b0;
    if (prefix_has(0, 2, "BM") && head_len() >= 18) begin
      for (int k = 0; k < 7; k++) if (dib == DIB_SIZES[k]) bitmap = 1'b1;
    end
    if (prefix_has(0, 8, PNG_MAGIC) || prefix_has(0, 3, 24'hFFD8FF) ||
        prefix_has(0, 6, "GIF87a") || prefix_has(0, 6, "GIF89a") ||
        prefix_has(0, 4, 32'h49492A00) || prefix_has(0, 4, 32'h4D4D002A) || bitmap) begin
      return fmc_pkg::CLASS_IMAGE;
    end
    if (prefix_has(0, 4, "RIFF")) begin
      if (prefix_has(8, 4, "WEBP")) return fmc_pkg::CLASS_IMAGE;
      if (prefix_has(8, 4, "AVI ") || prefix_has(8, 4, "WAVE")) return fmc_pkg::CLASS_MEDIA;
      return fmc_pkg::CLASS_UNKNOWN;
    end
    if (prefix_has(4, 4, "ftyp")) begin
      if (sequence_brand) return fmc_pkg::CLASS_UNKNOWN;
      return still_brand ? fmc_pkg::CLASS_IMAGE : fmc_pkg::CLASS_MEDIA;
    end
    media = prefix_has(0, 16, ASF_MAGIC);
    for (int k = 0; k < 6; k++) if (prefix_has(0, 4, MEDIA_MAGIC[k])) media = 1'b1;
    if (prefix_has(0, 3, "ID3") && head_len() > 3 && head_prefix[3] >= 2 &&
        head_prefix[3] <= 4) begin
      media = 1'b1;
    end
    if (media) return fmc_pkg::CLASS_MEDIA;
    zip = 1'b0;
    for (int k = 0; k < 3; k++) if (prefix_has(0, 4, ZIP_MARKS[k])) zip = 1'b1;
    if (zip) return fmc_pkg::CLASS_ZIP;
    if (pdf_found) return fmc_pkg::CLASS_PDF;
    return fmc_pkg::CLASS_UNKNOWN;
  endfunction

  function automatic void absorb_byte(int idx, fmc_pkg::byte_t d);
    int                off;
    longint unsigned   bound;
    if (idx < fmc_pkg::PREFIX_DEPTH) head_prefix[idx] = d;
    if (idx < 4) box_size = {box_size[23:0], d};
    brand_window = {brand_window[23:0], d};
    if (idx >= 11) begin
      off = idx - 3;
      bound = (box_size < 12) ? 64'd12 : 64'(box_size);
      if ((off == 8 || (off >= 16 && off % 4 == 0)) && longint'(off) + 4 <= bound) begin
        if (brand_listed(brand_window, 1'b0)) sequence_brand = 1'b1;
        if (brand_listed(brand_window, 1'b1)) still_brand = 1'b1;
      end
    end
    if (!pdf_found) begin
      if (pdf_progress < 5 && d == PDF_MARKER[8 * (4 - int'(pdf_progress)) +: 8]) begin
        pdf_progress++;
        if (pdf_progress == 5) begin
          pdf_found = 1'b1;
          pdf_progress = '0;
        end
      end else begin
        pdf_progress = (d == "%") ? 3'd1 : 3'd0;
      end
    end
  endfunction

  function automatic void take_request(fmc_pkg::byte_t d, logic last);
    fmc_pkg::result_t r;
    if (head_count < HEAD_LIMIT) begin
      absorb_byte(int'(head_count), d);
      head_count++;
    end else begin
      head_count = 13'(HEAD_LIMIT + 1);
    end
    if (last) begin
      r.fmt = classify_head();
      r.truncated = (head_count > HEAD_LIMIT);
      expected_classes.push_back(r);
      clear_head();
    end
  endfunction

  always @(posedge clk) begin
    fmc_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_classes.size() == 0) begin
          $error("unexpected result: format_class %0d, truncated %0d",
                 out_format_class, out_truncated);
          mismatch_count++;
        end else begin
          want = expected_classes.pop_front();
          if (out_format_class !== want.fmt) begin
            $error("format_class: expected %0d, actual %0d", want.fmt, out_format_class);
            mismatch_count++;
          end
          if (out_truncated !== want.truncated) begin
            $error("truncated: expected %0d, actual %0d", want.truncated, out_truncated);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) take_request(in_data_byte, in_last_byte);
    end
  end

  initial begin
    int pause;
    out_stall = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      pause = rx_idle ? $urandom_range(0, 14) : 0;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic void put_bytes(logic [127:0] v, int len);
    for (int k = 0; k < len; k++) head_bytes.push_back(v[8 * (len - 1 - k) +: 8]);
  endfunction

  function automatic void put_random(int n);
    for (int k = 0; k < n; k++) head_bytes.push_back(fmc_pkg::byte_t'($urandom));
  endfunction

  task automatic send_byte(input fmc_pkg::byte_t d, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_head();
    for (int k = 0; k < head_bytes.size(); k++) begin
      send_byte(head_bytes[k], k == head_bytes.size() - 1);
    end
  endtask

  task automatic send_sig(input logic [127:0] v, input int len, input int tail);
    head_bytes.delete();
    put_bytes(v, len);
    put_random(tail);
    send_head();
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_classes.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic test_signatures();
    send_sig(PNG_MAGIC, 8, 3);
    send_sig(PNG_MAGIC >> 24, 5, 0);
    send_sig(24'hFFD8FF, 3, 0);
    send_sig("GIF87a", 6, 2);
    send_sig("GIF89a", 6, 0);
    send_sig(32'h49492A00, 4, 1);
    send_sig(32'h4D4D002A, 4, 0);
    head_bytes.delete();
    put_bytes("BM", 2);
    put_random(12);
    put_bytes(32'h28000000, 4);
    send_head();
    head_bytes.delete();
    put_bytes("BM", 2);
    put_random(12);
    put_bytes(32'h7C000000, 4);
    put_random(6);
    send_head();
    head_bytes.delete();
    put_bytes("BM", 2);
    put_random(12);
    put_bytes(32'h29000000, 4);
    send_head();
    send_sig("BM", 2, 15);
    send_sig({"RIFF", 32'h12345678, "WEBP"}, 12, 0);
    send_sig({"RIFF", 32'h00000000, "AVI "}, 12, 4);
    send_sig({"RIFF", 32'hFFFFFFFF, "WAVE"}, 12, 0);
    send_sig({"RIFF", 32'h00000000, "XYZW"}, 12, 0);
    send_sig({32'h00000018, "ftyp", "heic", 32'h0}, 16, 0);
    head_bytes.delete();
    put_bytes({32'h00000018, "ftyp", "heic", 32'h0}, 16);
    put_bytes({"mif1", "msf1"}, 8);
    send_head();
    send_sig({32'h00000014, "ftyp", "mp42", 32'h0, "isom"}, 20, 0);
    send_sig({32'h00000010, "ftyp", "mp42", 32'h0, "mif1"}, 20, 0);
    send_sig({32'h00000000, "ftyp", "avif"}, 12, 0);
    for (int k = 0; k < 6; k++) send_sig(MEDIA_MAGIC[k], 4, k);
    send_sig(ASF_MAGIC, 16, 0);
    send_sig({"ID3", 8'h03}, 4, 2);
    send_sig({"ID3", 8'h05}, 4, 0);
    send_sig("ID3", 3, 0);
    for (int k = 0; k < 3; k++) send_sig(ZIP_MARKS[k], 4, 1);
    send_sig("xy%%PDF-1.4", 11, 0);
    send_sig(8'h00, 1, 0);
    send_sig(8'hFF, 1, 0);
  endtask

  task automatic test_truncation();
    tx_idle = 1'b0;
    head_bytes.delete();
    put_bytes(PNG_MAGIC, 8);
    put_random(HEAD_LIMIT - 8);
    send_head();
    head_bytes.delete();
    put_random(HEAD_LIMIT - 2);
    put_bytes(PDF_MARKER, 5);
    send_head();
    head_bytes.delete();
    put_bytes({32'h00000800, "ftyp", "mp42"}, 12);
    put_random(4);
    while (head_bytes.size() < 2000) put_bytes("isom", 4);
    put_bytes("heic", 4);
    put_random(HEAD_LIMIT + 40 - head_bytes.size());
    send_head();
    tx_idle = 1'b1;
  endtask

  // The receiver holds off while short heads keep coming, so the result
  // buffer fills and the input channel must stall.
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold_cycles = 300;
    for (int n = 0; n < 40; n++) begin
      head_bytes.delete();
      put_random(1 + n % 3);
      send_head();
    end
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_random();
    int          sent;
    int          tail;
    int          cut;
    int          idx;
    int          nbrands;
    logic [31:0] v;
    sent = 0;
    while (sent < 1700) begin
      head_bytes.delete();
      case ($urandom_range(0, 12))
        0: put_bytes(PNG_MAGIC, 8);
        1: put_bytes(24'hFFD8FF, 3);
        2: put_bytes($urandom_range(0, 1) ? "GIF87a" : "GIF89a", 6);
        3: put_bytes($urandom_range(0, 1) ? 32'h49492A00 : 32'h4D4D002A, 4);
        4: begin
          put_bytes("BM", 2);
          put_random(12);
          case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 130);
            1: v = $urandom;
            default: v = DIB_SIZES[$urandom_range(0, 6)];
          endcase
          put_bytes({v[7:0], v[15:8], v[23:16], v[31:24]}, 4);
        end
        5: begin
          put_bytes("RIFF", 4);
          put_random(4);
          case ($urandom_range(0, 3))
            0: put_bytes("WEBP", 4);
            1: put_bytes("AVI ", 4);
            2: put_bytes("WAVE", 4);
            default: put_random(4);
          endcase
        end
        6: begin
          case ($urandom_range(0, 5))
            0: v = 0;
            1: v = $urandom;
            2: v = $urandom_range(0, 40);
            default: v = 12 + 4 * $urandom_range(0, 4);
          endcase
          put_bytes({v, "ftyp"}, 8);
          nbrands = $urandom_range(1, 5);
          for (int k = 0; k < nbrands; k++) begin
            case ($urandom_range(0, 3))
              0: v = SEQUENCE_BRANDS[$urandom_range(0, 6)];
              1: v = STILL_BRANDS[$urandom_range(0, 8)];
              2: v = $urandom_range(0, 1) ? "mp42" : "isom";
              default: v = $urandom;
            endcase
            put_bytes(v, 4);
            if (k == 0) put_random(4);
          end
        end
        7: put_bytes(MEDIA_MAGIC[$urandom_range(0, 5)], 4);
        8: put_bytes(ASF_MAGIC, 16);
        9: begin
          put_bytes("ID3", 3);
          head_bytes.push_back(fmc_pkg::byte_t'($urandom_range(0, 7)));
        end
        10: put_bytes(ZIP_MARKS[$urandom_range(0, 2)], 4);
        11: begin
          put_random($urandom_range(0, 30));
          put_bytes(PDF_MARKER, 5);
        end
        default: ;
      endcase
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
      put_random(tail);
      if (head_bytes.size() == 0) put_random(1);
      if ($urandom_range(0, 7) == 0) begin
        idx = $urandom_range(0, head_bytes.size() - 1);
        head_bytes[idx] = head_bytes[idx] ^ fmc_pkg::byte_t'(1 << $urandom_range(0, 7));
      end
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, head_bytes.size());
        while (head_bytes.size() > cut) void'(head_bytes.pop_back());
      end
      sent += head_bytes.size();
      if ($urandom_range(0, 29) == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
      send_head();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    rst_n = 1'b0;
    clear_head();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_signatures();
    wait_drained();
    test_truncation();
    wait_drained();
    test_backpressure();
    test_random();
    wait_drained();
    if (expected_classes.size() != 0) begin
      $error("%0d expected results never arrived", expected_classes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- file_magic_classifier.f -----
rtl/core/fmc_pkg.sv
rtl/core/fmc_tracker.sv
rtl/core/fmc_classify.sv
rtl/core/fmc_out_buf.sv
rtl/core/file_magic_classifier.sv
tb/file_magic_classifier_tb.sv
